// ===== rtl/smfh_pkg.sv =====
// ----------------------------------------------------------------------------
// smfh_pkg
// Shared constants, state and job encodings, and controller/datapath links
// for the streaming multiply-fold 64-bit hash unit.
// ----------------------------------------------------------------------------
package smfh_pkg;

  localparam int unsigned BLOCK_BYTES = 32;
  localparam int unsigned ADDR_W      = $clog2(BLOCK_BYTES);
  localparam int unsigned CNT_W       = ADDR_W + 1;

  localparam logic [63:0] K0 = 64'h6a09e667f3bcc909;
  localparam logic [63:0] K1 = 64'hbb67ae8584caa73b;
  localparam logic [63:0] K2 = 64'h3c6ef372fe94f82b;
  localparam logic [63:0] K3 = 64'ha54ff53a5f1d36f1;
  localparam logic [63:0] K4 = 64'h510e527fade682d1;
  localparam logic [63:0] K5 = 64'h9b05688c2b3e6c1f;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_CHECK,
    ST_END,
    ST_GATHER,
    ST_LOAD,
    ST_MUL,
    ST_APPLY,
    ST_FIN_PRE,
    ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    JOB_SEED,
    JOB_M0,
    JOB_M1,
    JOB_SW,
    JOB_F1,
    JOB_F2,
    JOB_F3
  } job_t;

  typedef struct packed {
    logic              gather_start;
    logic              gather_short;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_idx;
    logic              load;
    job_t              job;
    logic              mul_en;
    logic [1:0]        mul_idx;
    logic              acc_en;
    logic [1:0]        acc_idx;
    logic              apply;
    logic              dest_chain;
    logic              h_from_chain;
    logic              fin_pre;
    logic              out_load;
  } cmd_t;

  typedef struct packed {
    logic live;
    logic start;
    logic last;
    logic full;
    logic cnt_zero;
    logic lt_block;
    logic ge8;
  } status_t;

endpackage

// ===== rtl/smfh_if.sv =====
// ----------------------------------------------------------------------------
// smfh channel interfaces
// Valid/ready channels for input bytes, digests and the seed register write.
// ----------------------------------------------------------------------------
interface smfh_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       last_byte;
  modport source (output valid, output data_byte, output has_byte, output last_byte,
                  input ready);
  modport sink (input valid, input data_byte, input has_byte, input last_byte,
                output ready);
endinterface

interface smfh_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest;
  modport source (output valid, output digest, input ready);
  modport sink (input valid, input digest, output ready);
endinterface

interface smfh_cfg_if;
  logic        valid;
  logic        ready;
  logic [63:0] seed;
  modport source (output valid, output seed, input ready);
  modport sink (input valid, input seed, output ready);
endinterface

// ===== rtl/smfh_ram.sv =====
// ----------------------------------------------------------------------------
// smfh_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module smfh_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

// ===== rtl/smfh_ctrl.sv =====
// ----------------------------------------------------------------------------
// smfh_ctrl
// Sequencer: message start, block absorb, length classes, finish rounds and
// output register handoff.
// ----------------------------------------------------------------------------
module smfh_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  smfh_pkg::status_t status,
  output smfh_pkg::cmd_t    cmd
);

  smfh_pkg::state_t              state_r, state_nxt;
  smfh_pkg::job_t                job_r, job_nxt;
  logic                          dest_r, dest_nxt;
  logic [smfh_pkg::CNT_W-1:0]    gcnt_r, gcnt_nxt;
  logic [2:0]                    mcnt_r, mcnt_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic                          out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    job_nxt   = job_r;
    dest_nxt  = dest_r;
    case (state_r)
      smfh_pkg::ST_IDLE: begin
        if (in_valid && status.live) state_nxt = smfh_pkg::ST_DECIDE;
      end
      smfh_pkg::ST_DECIDE: begin
        if (status.start) begin
          job_nxt   = smfh_pkg::JOB_SEED;
          state_nxt = smfh_pkg::ST_LOAD;
        end else begin
          state_nxt = smfh_pkg::ST_CHECK;
        end
      end
      smfh_pkg::ST_CHECK: begin
        if (status.full) begin
          job_nxt   = smfh_pkg::JOB_M0;
          dest_nxt  = 1'b1;
          state_nxt = smfh_pkg::ST_GATHER;
        end else if (status.last) begin
          state_nxt = smfh_pkg::ST_END;
        end else begin
          state_nxt = smfh_pkg::ST_IDLE;
        end
      end
      smfh_pkg::ST_END: begin
        dest_nxt = 1'b0;
        if (status.lt_block) begin
          if (status.cnt_zero) begin
            job_nxt   = smfh_pkg::JOB_SW;
            state_nxt = smfh_pkg::ST_LOAD;
          end else if (status.ge8) begin
            job_nxt   = smfh_pkg::JOB_M0;
            state_nxt = smfh_pkg::ST_GATHER;
          end else begin
            job_nxt   = smfh_pkg::JOB_SW;
            state_nxt = smfh_pkg::ST_GATHER;
          end
        end else if (!status.cnt_zero) begin
          job_nxt   = smfh_pkg::JOB_M0;
          state_nxt = smfh_pkg::ST_GATHER;
        end else begin
          state_nxt = smfh_pkg::ST_FIN_PRE;
        end
      end
      smfh_pkg::ST_GATHER: begin
        if (gcnt_r == smfh_pkg::CNT_W'(smfh_pkg::BLOCK_BYTES)) state_nxt = smfh_pkg::ST_LOAD;
      end
      smfh_pkg::ST_LOAD: begin
        state_nxt = smfh_pkg::ST_MUL;
      end
      smfh_pkg::ST_MUL: begin
        if (mcnt_r == 3'd4) state_nxt = smfh_pkg::ST_APPLY;
      end
      smfh_pkg::ST_APPLY: begin
        case (job_r)
          smfh_pkg::JOB_SEED: state_nxt = smfh_pkg::ST_CHECK;
          smfh_pkg::JOB_M0: begin
            job_nxt   = smfh_pkg::JOB_M1;
            state_nxt = smfh_pkg::ST_LOAD;
          end
          smfh_pkg::JOB_M1: state_nxt = dest_r ? smfh_pkg::ST_CHECK : smfh_pkg::ST_FIN_PRE;
          smfh_pkg::JOB_SW: state_nxt = smfh_pkg::ST_FIN_PRE;
          smfh_pkg::JOB_F1: begin
            job_nxt   = smfh_pkg::JOB_F2;
            state_nxt = smfh_pkg::ST_LOAD;
          end
          smfh_pkg::JOB_F2: begin
            job_nxt   = smfh_pkg::JOB_F3;
            state_nxt = smfh_pkg::ST_LOAD;
          end
          smfh_pkg::JOB_F3: state_nxt = smfh_pkg::ST_OUT;
          default: state_nxt = smfh_pkg::ST_IDLE;
        endcase
      end
      smfh_pkg::ST_FIN_PRE: begin
        job_nxt   = smfh_pkg::JOB_F1;
        state_nxt = smfh_pkg::ST_LOAD;
      end
      smfh_pkg::ST_OUT: begin
        if (out_free) state_nxt = smfh_pkg::ST_IDLE;
      end
      default: state_nxt = smfh_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd              = '0;
    cmd.job          = job_r;
    cmd.dest_chain   = dest_r;
    cmd.rd_idx       = gcnt_r[smfh_pkg::ADDR_W-1:0];
    cmd.mul_idx      = mcnt_r[1:0];
    cmd.acc_idx      = 2'(mcnt_r - 3'd1);
    in_ready         = 1'b0;
    case (state_r)
      smfh_pkg::ST_IDLE: in_ready = 1'b1;
      smfh_pkg::ST_CHECK: cmd.gather_start = status.full;
      smfh_pkg::ST_END: begin
        cmd.gather_start = !status.cnt_zero;
        cmd.gather_short = status.lt_block;
        cmd.h_from_chain = !status.lt_block && status.cnt_zero;
      end
      smfh_pkg::ST_GATHER: cmd.rd_en = !gcnt_r[smfh_pkg::CNT_W-1];
      smfh_pkg::ST_LOAD: cmd.load = 1'b1;
      smfh_pkg::ST_MUL: begin
        cmd.mul_en = (mcnt_r != 3'd4);
        cmd.acc_en = (mcnt_r != 3'd0);
      end
      smfh_pkg::ST_APPLY: cmd.apply = 1'b1;
      smfh_pkg::ST_FIN_PRE: cmd.fin_pre = 1'b1;
      smfh_pkg::ST_OUT: cmd.out_load = out_free;
      default: in_ready = 1'b0;
    endcase
  end

  always_comb begin
    gcnt_nxt      = (state_r == smfh_pkg::ST_GATHER) ? gcnt_r + 1'b1 : '0;
    mcnt_nxt      = (state_r == smfh_pkg::ST_MUL) ? mcnt_r + 3'd1 : 3'd0;
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= smfh_pkg::ST_IDLE;
      job_r       <= smfh_pkg::JOB_SEED;
      dest_r      <= 1'b0;
      gcnt_r      <= '0;
      mcnt_r      <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      job_r       <= job_nxt;
      dest_r      <= dest_nxt;
      gcnt_r      <= gcnt_nxt;
      mcnt_r      <= mcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== rtl/smfh_datapath.sv =====
// ----------------------------------------------------------------------------
// smfh_datapath
// Byte buffer, word gather, shared 32x32 multiplier with 128-bit accumulate,
// chaining value, lengths and digest register.
// ----------------------------------------------------------------------------
module smfh_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_acc,
  input  logic              in_live,
  input  logic [7:0]        data_byte,
  input  logic              has_byte,
  input  logic              last_byte,
  input  logic              cfg_we,
  input  logic [63:0]       cfg_seed,
  input  smfh_pkg::cmd_t    cmd,
  output smfh_pkg::status_t status,
  output logic [63:0]       digest
);

  localparam int unsigned AW = smfh_pkg::ADDR_W;
  localparam int unsigned CW = smfh_pkg::CNT_W;

  logic [63:0]       seed_r, xseed_r, chain_r, h_r, t_r, total_r, digest_r;
  logic [CW-1:0]     cnt_r;
  logic              start_r, last_r, short_r;
  logic [3:0][63:0]  words_r;
  logic [63:0]       ma_r, mb_r, pp_r;
  logic [127:0]      acc_r;
  logic [AW-1:0]     ridx_r;
  logic              rmask_r, rvld_r;

  logic [7:0]        rdata;
  logic [AW-1:0]     len, raddr;
  logic [AW-1:0]     base [4];
  logic              rmask;
  logic [63:0]       sw, xs_swap, ma_nxt, mb_nxt, fold, low, fin_x;
  logic [31:0]       a_half, b_half;
  logic [127:0]      pp_ext;

  smfh_ram #(.WIDTH(8), .DEPTH(smfh_pkg::BLOCK_BYTES)) u_ram (
    .clk   (clk),
    .we    (in_acc && has_byte),
    .waddr (cnt_r[AW-1:0]),
    .wdata (data_byte),
    .re    (cmd.rd_en),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign len = cnt_r[AW-1:0];

  always_comb begin
    base[0] = '0;
    base[1] = AW'(8);
    base[2] = AW'(16);
    base[3] = AW'(24);
    if (short_r) begin
      if (len >= AW'(8)) begin
        base[1] = (len >= AW'(16)) ? AW'(8) : '0;
        base[2] = (len >= AW'(16)) ? len - AW'(16) : '0;
        base[3] = len - AW'(8);
      end else if (len >= AW'(4)) begin
        base[1] = len - AW'(4);
        base[2] = '0;
        base[3] = '0;
      end else begin
        base[1] = len >> 1;
        base[2] = len - AW'(1);
        base[3] = '0;
      end
    end
  end

  assign raddr = base[cmd.rd_idx[AW-1:3]] + AW'(cmd.rd_idx[2:0]);
  assign rmask = short_r || ({1'b0, raddr} < cnt_r);

  always_comb begin
    if (len >= AW'(4)) begin
      sw = {words_r[0][31:0], words_r[1][31:0]};
    end else if (len != '0) begin
      sw = {40'd0, words_r[0][7:0], words_r[1][7:0], words_r[2][7:0]};
    end else begin
      sw = '0;
    end
  end

  assign xs_swap = {xseed_r[31:0], xseed_r[63:32]};

  always_comb begin
    ma_nxt = h_r;
    mb_nxt = smfh_pkg::K3;
    case (cmd.job)
      smfh_pkg::JOB_SEED: begin
        ma_nxt = seed_r ^ smfh_pkg::K0;
        mb_nxt = smfh_pkg::K5;
      end
      smfh_pkg::JOB_M0: begin
        if (short_r) begin
          ma_nxt = words_r[0] ^ smfh_pkg::K1 ^ xseed_r;
          mb_nxt = words_r[1] ^ smfh_pkg::K2 ^ xs_swap;
        end else begin
          ma_nxt = chain_r ^ words_r[0] ^ smfh_pkg::K1;
          mb_nxt = chain_r ^ words_r[1] ^ smfh_pkg::K2;
        end
      end
      smfh_pkg::JOB_M1: begin
        ma_nxt = words_r[2] ^ smfh_pkg::K3;
        mb_nxt = words_r[3] ^ smfh_pkg::K4;
      end
      smfh_pkg::JOB_SW: begin
        ma_nxt = sw ^ smfh_pkg::K1 ^ xseed_r;
        mb_nxt = smfh_pkg::K2 ^ xs_swap;
      end
      smfh_pkg::JOB_F1: mb_nxt = smfh_pkg::K3;
      smfh_pkg::JOB_F2: mb_nxt = smfh_pkg::K5;
      smfh_pkg::JOB_F3: mb_nxt = smfh_pkg::K4;
      default: mb_nxt = smfh_pkg::K3;
    endcase
  end

  assign a_half = cmd.mul_idx[1] ? ma_r[63:32] : ma_r[31:0];
  assign b_half = cmd.mul_idx[0] ? mb_r[63:32] : mb_r[31:0];

  always_comb begin
    pp_ext = {64'd0, pp_r};
    case (cmd.acc_idx)
      2'd0: pp_ext = {64'd0, pp_r};
      2'd1, 2'd2: pp_ext = {32'd0, pp_r, 32'd0};
      2'd3: pp_ext = {pp_r, 64'd0};
      default: pp_ext = {64'd0, pp_r};
    endcase
  end

  assign low   = acc_r[63:0];
  assign fold  = acc_r[63:0] ^ acc_r[127:64] ^ ma_r ^ mb_r;
  assign fin_x = h_r ^ total_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r  <= '0;
      total_r <= '0;
      cnt_r   <= '0;
      start_r <= 1'b0;
      last_r  <= 1'b0;
      rvld_r  <= 1'b0;
    end else begin
      if (cfg_we) seed_r <= cfg_seed;
      rvld_r <= cmd.rd_en;
      if (in_acc && in_live) begin
        start_r <= (total_r == '0) && (cnt_r == '0);
        last_r  <= last_byte;
        if (has_byte) begin
          cnt_r   <= cnt_r + 1'b1;
          total_r <= total_r + 64'd1;
        end
      end
      if (cmd.apply && cmd.job == smfh_pkg::JOB_M1 && cmd.dest_chain) cnt_r <= '0;
      if (cmd.out_load) begin
        cnt_r   <= '0;
        total_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.gather_start) short_r <= cmd.gather_short;
    if (cmd.rd_en) begin
      ridx_r  <= cmd.rd_idx;
      rmask_r <= rmask;
    end
    if (rvld_r) begin
      words_r[ridx_r[AW-1:3]][{ridx_r[2:0], 3'b000} +: 8] <= rmask_r ? rdata : 8'd0;
    end
    if (cmd.load) begin
      ma_r  <= ma_nxt;
      mb_r  <= mb_nxt;
      acc_r <= '0;
    end
    if (cmd.mul_en) pp_r <= 64'(a_half) * 64'(b_half);
    if (cmd.acc_en) acc_r <= acc_r + pp_ext;
    if (cmd.h_from_chain) h_r <= chain_r;
    if (cmd.fin_pre) h_r <= fin_x ^ (fin_x >> 32);
    if (cmd.apply) begin
      case (cmd.job)
        smfh_pkg::JOB_SEED: begin
          xseed_r <= fold;
          chain_r <= fold ^ smfh_pkg::K0;
        end
        smfh_pkg::JOB_M0: t_r <= fold;
        smfh_pkg::JOB_M1: begin
          if (cmd.dest_chain) begin
            chain_r <= t_r ^ fold ^ smfh_pkg::K0;
          end else begin
            h_r <= t_r ^ fold ^ smfh_pkg::K0;
          end
        end
        smfh_pkg::JOB_SW: h_r <= fold;
        smfh_pkg::JOB_F2: h_r <= low ^ (low >> 32);
        smfh_pkg::JOB_F1, smfh_pkg::JOB_F3: h_r <= low ^ (low >> 29);
        default: h_r <= h_r;
      endcase
    end
    if (cmd.out_load) digest_r <= h_r;
  end

  assign status.live     = in_live;
  assign status.start    = start_r;
  assign status.last     = last_r;
  assign status.full     = cnt_r[CW-1];
  assign status.cnt_zero = (cnt_r == '0);
  assign status.lt_block = (total_r[63:AW] == '0);
  assign status.ge8      = |cnt_r[CW-1:3];
  assign digest          = digest_r;

endmodule

// ===== rtl/streaming_multiply_fold_hash64_unit.sv =====
// ----------------------------------------------------------------------------
// streaming_multiply_fold_hash64_unit
// Byte-serial 64-bit multiply-fold hash with seed expansion, 32-byte block
// absorb, short-message length classes and a three-round finish.
// ----------------------------------------------------------------------------
//  channel | dir | handshake    | payload
//  in_ch   | in  | valid/ready  | data_byte[7:0], has_byte, last_byte
//  out_ch  | out | valid/ready  | digest[63:0]
//  cfg_ch  | in  | valid/ready  | seed[63:0]
//
//  A byte that does not fill the block passes the decide and check states;
//  the first item of a message also runs seed expansion. A full block adds
//  a byte gather from the buffer RAM, two passes of the 32x32 multiplier
//  and a second check. The last item adds the tail or short class and
//  three finish rounds. Reset is synchronous; no clearing pass. A stalled
//  digest holds the next message only once its own digest is ready.
// ----------------------------------------------------------------------------
module streaming_multiply_fold_hash64_unit (
  input  logic        clk,
  input  logic        rst_n,
  smfh_in_if.sink     in_ch,
  smfh_out_if.source  out_ch,
  smfh_cfg_if.sink    cfg_ch
);

  smfh_pkg::cmd_t    cmd;
  smfh_pkg::status_t status;
  logic              in_acc;

  assign cfg_ch.ready = 1'b1;
  assign in_acc       = in_ch.valid && in_ch.ready;

  smfh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  smfh_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_acc    (in_acc),
    .in_live   (in_ch.has_byte || in_ch.last_byte),
    .data_byte (in_ch.data_byte),
    .has_byte  (in_ch.has_byte),
    .last_byte (in_ch.last_byte),
    .cfg_we    (cfg_ch.valid && cfg_ch.ready),
    .cfg_seed  (cfg_ch.seed),
    .cmd       (cmd),
    .status    (status),
    .digest    (out_ch.digest)
  );

  a_no_gather_when_ready : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_en |-> !in_ch.ready)
    else $error("buffer gather while input open");

  a_out_load_free : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_ch.valid || out_ch.ready))
    else $error("digest overwritten while waiting");

  a_last_goes_busy : assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.last_byte) |=> !in_ch.ready)
    else $error("last item did not start finish");

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Checks the streaming multiply-fold hash unit against a local digest
// predictor: directed length classes, special items, seeds, random messages.
// ----------------------------------------------------------------------------
module tb;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #1 clk = ~clk;

  smfh_in_if  in_ch ();
  smfh_out_if out_ch ();
  smfh_cfg_if cfg_ch ();

  streaming_multiply_fold_hash64_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  logic [63:0] seed_reg;
  logic [63:0] xseed;
  logic [63:0] chain;
  logic [7:0]  buf_mem [smfh_pkg::BLOCK_BYTES];
  int unsigned buf_cnt;
  logic [63:0] total_len;
  logic [63:0] digest_q[$];
  int          mismatches = 0;
  int          out_wait = 0;
  longint      cycles = 0;

  function automatic logic [63:0] fold_mul(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[63:0] ^ p[127:64] ^ a ^ b;
  endfunction

  function automatic logic [63:0] swap_halves(logic [63:0] x);
    return {x[31:0], x[63:32]};
  endfunction

  function automatic logic [63:0] word_le(int unsigned off, int unsigned n);
    logic [63:0] v;
    v = '0;
    for (int i = 0; i < n; i++) v[8*i +: 8] = buf_mem[(off + i) % smfh_pkg::BLOCK_BYTES];
    return v;
  endfunction

  function automatic logic [63:0] absorb(logic [63:0] h);
    logic [63:0] m0, m1;
    m0 = fold_mul(h ^ word_le(0, 8) ^ smfh_pkg::K1, h ^ word_le(8, 8) ^ smfh_pkg::K2);
    m1 = fold_mul(word_le(16, 8) ^ smfh_pkg::K3, word_le(24, 8) ^ smfh_pkg::K4);
    return m0 ^ m1 ^ smfh_pkg::K0;
  endfunction

  function automatic logic [63:0] short_digest(int unsigned len, logic [63:0] s);
    logic [63:0] w, m0, m1;
    int unsigned o1, o2;
    if (len >= 8) begin
      o1 = (len >= 16) ? 8 : 0;
      o2 = (len >= 16) ? len - 16 : 0;
      m0 = fold_mul(word_le(0, 8) ^ smfh_pkg::K1 ^ s,
                    word_le(o1, 8) ^ smfh_pkg::K2 ^ swap_halves(s));
      m1 = fold_mul(word_le(o2, 8) ^ smfh_pkg::K3, word_le(len - 8, 8) ^ smfh_pkg::K4);
      return m0 ^ m1 ^ smfh_pkg::K0;
    end
    if (len >= 4) w = (word_le(0, 4) << 32) | word_le(len - 4, 4);
    else if (len > 0) w = {40'd0, buf_mem[0], buf_mem[len >> 1], buf_mem[len - 1]};
    else w = '0;
    return fold_mul(w ^ smfh_pkg::K1 ^ s, smfh_pkg::K2 ^ swap_halves(s));
  endfunction

  function automatic logic [63:0] finish_rounds(logic [63:0] h, logic [63:0] t);
    h ^= t;
    h ^= h >> 32;
    h *= smfh_pkg::K3;
    h ^= h >> 29;
    h *= smfh_pkg::K5;
    h ^= h >> 32;
    h *= smfh_pkg::K4;
    h ^= h >> 29;
    return h;
  endfunction

  function automatic void predict_item(logic [7:0] b, logic has, logic last);
    logic [63:0] h;
    if (!has && !last) return;
    if (total_len == 0 && buf_cnt == 0) begin
      xseed = fold_mul(seed_reg ^ smfh_pkg::K0, smfh_pkg::K5);
      chain = xseed ^ smfh_pkg::K0;
    end
    if (has) begin
      buf_mem[buf_cnt] = b;
      buf_cnt++;
      total_len++;
      if (buf_cnt == smfh_pkg::BLOCK_BYTES) begin
        chain = absorb(chain);
        buf_cnt = 0;
      end
    end
    if (!last) return;
    h = chain;
    if (total_len < smfh_pkg::BLOCK_BYTES) h = short_digest(buf_cnt, xseed);
    else if (buf_cnt != 0) begin
      for (int i = buf_cnt; i < smfh_pkg::BLOCK_BYTES; i++) buf_mem[i] = 8'd0;
      h = absorb(h);
    end
    digest_q.push_back(finish_rounds(h, total_len));
    total_len = 0;
    buf_cnt = 0;
  endfunction

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.has_byte = 1'b0;
    in_ch.last_byte = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.seed = '0;
    seed_reg = '0;
    buf_cnt = 0;
    total_len = '0;
    for (int i = 0; i < smfh_pkg::BLOCK_BYTES; i++) buf_mem[i] = 8'd0;
  end

  task automatic send_item(logic [7:0] b, logic has, logic last);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.has_byte <= has;
    in_ch.last_byte <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_item(b, has, last);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_seed(logic [63:0] s);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.seed <= s;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    seed_reg = s;
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_message(int unsigned len, int pattern);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      b = (pattern == 0) ? 8'h00 : (pattern == 1) ? 8'hff : 8'($urandom);
      send_item(b, 1'b1, i == len - 1);
    end
    if (len == 0) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (digest_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected digest %h", out_ch.digest);
        end else begin
          if (out_ch.digest !== digest_q[0]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("digest exp %h got %h", digest_q[0], out_ch.digest);
          end
          void'(digest_q.pop_front());
        end
        out_wait = $urandom_range(0, 4);
        out_ch.ready <= (out_wait == 0);
      end else if (out_ch.valid) begin
        if (out_wait > 0) out_wait--;
        out_ch.ready <= (out_wait == 0);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 3000000) begin
      $display("streaming_multiply_fold_hash64_unit: mismatch");
      $finish;
    end
  end

  task automatic test_length_classes();
    int lens[12] = '{0, 1, 2, 3, 4, 7, 8, 15, 16, 31, 32, 33};
    foreach (lens[i]) send_message(lens[i], 2);
  endtask

  task automatic test_special_items();
    send_item(8'h5a, 1'b0, 1'b0);
    send_message(5, 0);
    send_message(40, 1);
    send_item(8'h11, 1'b1, 1'b0);
    send_item(8'h22, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'h33, 1'b0, 1'b1);
    for (int i = 0; i < 32; i++) send_item(8'($urandom), 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
  endtask

  task automatic test_seeds();
    write_seed(64'hffff_ffff_ffff_ffff);
    send_message(0, 2);
    send_message(20, 2);
    write_seed({$urandom, $urandom});
    send_message(6, 2);
    send_message(64, 2);
  endtask

  task automatic test_random_messages();
    int sent;
    int len;
    sent = 0;
    while (sent < 1250) begin
      if ($urandom_range(0, 19) == 0) write_seed({$urandom, $urandom});
      if ($urandom_range(0, 24) == 0) drain();
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(32, 100) : $urandom_range(0, 31);
      if ($urandom_range(0, 9) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      if (len > 0 && $urandom_range(0, 9) == 0) begin
        for (int i = 0; i < len; i++) send_item(8'($urandom), 1'b1, 1'b0);
        send_item(8'($urandom), 1'b0, 1'b1);
      end else begin
        send_message(len, 2);
      end
      sent += len + 1;
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_length_classes();
    test_special_items();
    test_seeds();
    write_seed(64'd0);
    test_random_messages();
    drain();
    if (mismatches == 0 && digest_q.size() == 0) begin
      $display("streaming_multiply_fold_hash64_unit: match");
    end else begin
      $display("streaming_multiply_fold_hash64_unit: mismatch");
    end
    $finish;
  end

endmodule
